// File: sv/adsr_envelope_generator_top_assert.svh
// Assertion macros for the ADSR envelope generator.
// Expects clk and arst_n in the scope of each use; ASSERT_OFF removes the checks.
`ifndef ADSR_ENVELOPE_GENERATOR_TOP_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define ADSR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ADSR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ADSR_ASSERT_IMP(lbl, ante, cons, msg)
`define ADSR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/adsr_pkg.sv
// Shared constants and codes for the ADSR envelope generator.
// No dependencies; used by the top level and the testbench.
`default_nettype none
package adsr_pkg;

	// default parameter values
	localparam int TIME_BITS_DEF       = 32;
	localparam int LEVEL_FRAC_BITS_DEF = 15;

	// fixed register and field widths
	localparam int CFG_W   = 24;
	localparam int LVLCF_W = 16;
	localparam int FIELD_W = 32;
	localparam int OUT_W   = 16;
	localparam int IDX_W   = 3;

	// register reset values
	localparam logic [CFG_W-1:0]   ATTACK_RST  = 24'd4410;
	localparam logic [CFG_W-1:0]   DECAY_RST   = 24'd4410;
	localparam logic [CFG_W-1:0]   RELEASE_RST = 24'd8820;
	localparam logic [LVLCF_W-1:0] START_RST   = 16'd32768;
	localparam logic [LVLCF_W-1:0] SUSTAIN_RST = 16'd32768;
	localparam logic [LVLCF_W-1:0] FLOOR_RST   = 16'd328;

	typedef enum logic [IDX_W-1:0] {
		REG_ATTACK  = 3'd0,
		REG_DECAY   = 3'd1,
		REG_RELEASE = 3'd2,
		REG_START   = 3'd3,
		REG_SUSTAIN = 3'd4,
		REG_FLOOR   = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_ATTACK  = 2'd0,
		PH_DECAY   = 2'd1,
		PH_SUSTAIN = 2'd2,
		PH_RELEASE = 2'd3
	} phase_t;

endpackage
`default_nettype wire

// File: sv/adsr_div_cell.sv
// One restoring-division cell: resolves one quotient bit per word and stage.
// Standalone; instanced in a row by adsr_divider.
`default_nettype none
module adsr_div_cell #(
	parameter int DW  = 24,
	parameter int QB  = 16,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [DW-1:0]  in_rem,
	input  logic [QB-1:0]  in_work,
	input  logic [DW-1:0]  in_den,
	input  logic [SBW-1:0] in_sb,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [DW-1:0]  out_rem,
	output logic [QB-1:0]  out_work,
	output logic [DW-1:0]  out_den,
	output logic [SBW-1:0] out_sb
);

	logic           v_q;
	logic [DW-1:0]  rem_q;
	logic [QB-1:0]  work_q;
	logic [DW-1:0]  den_q;
	logic [SBW-1:0] sb_q;
	logic [DW:0]    trial;
	logic [DW:0]    diff;
	logic           ge;

	assign in_ready = !v_q || out_ready;

	// shift in next numerator bit, subtract when it fits
	always_comb begin
		trial = {in_rem, in_work[QB-1]};
		diff  = trial - {1'b0, in_den};
		ge    = trial >= {1'b0, in_den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			work_q <= {in_work[QB-2:0], ge};
			den_q  <= in_den;
			sb_q   <= in_sb;
		end
	end

	assign out_valid = v_q;
	assign out_rem   = rem_q;
	assign out_work  = work_q;
	assign out_den   = den_q;
	assign out_sb    = sb_q;

endmodule
`default_nettype wire

// File: sv/adsr_divider.sv
// Pipelined unsigned divider: a row of QB adsr_div_cell stages.
// Quotient must fit in QB bits; a sideband word rides along unchanged.
`default_nettype none
module adsr_divider #(
	parameter int DW  = 24,
	parameter int QB  = 16,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [DW+QB-1:0] in_num,
	input  logic [DW-1:0]  in_den,
	input  logic [SBW-1:0] in_sb,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [QB-1:0]  out_quo,
	output logic [SBW-1:0] out_sb
);

	logic [DW-1:0]  rem_c  [QB+1];
	logic [QB-1:0]  work_c [QB+1];
	logic [DW-1:0]  den_c  [QB+1];
	logic [SBW-1:0] sb_c   [QB+1];
	logic [QB:0]    v_c;
	logic [QB:0]    r_c;

	// head of the row: high part is the running remainder
	assign rem_c[0]  = in_num[DW+QB-1:QB];
	assign work_c[0] = in_num[QB-1:0];
	assign den_c[0]  = in_den;
	assign sb_c[0]   = in_sb;
	assign v_c[0]    = in_valid;
	assign in_ready  = r_c[0];
	assign r_c[QB]   = out_ready;

	for (genvar i = 0; i < QB; i++) begin : g_cell
		adsr_div_cell #(.DW(DW), .QB(QB), .SBW(SBW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_c[i]),
			.in_ready (r_c[i]),
			.in_rem   (rem_c[i]),
			.in_work  (work_c[i]),
			.in_den   (den_c[i]),
			.in_sb    (sb_c[i]),
			.out_valid(v_c[i+1]),
			.out_ready(r_c[i+1]),
			.out_rem  (rem_c[i+1]),
			.out_work (work_c[i+1]),
			.out_den  (den_c[i+1]),
			.out_sb   (sb_c[i+1])
		);
	end

	assign out_valid = v_c[QB];
	assign out_quo   = work_c[QB];
	assign out_sb    = sb_c[QB];

endmodule
`default_nettype wire

// File: sv/adsr_envelope_generator_top.sv
// Linear ADSR envelope generator, one query per cycle when unstalled.
// Pipeline: three front stages, a held-curve divider row, two stages,
// a release divider row and the output register.
// Throughput one word per cycle when unstalled; set by the one-bit-per-stage divider cells.
// Reset clears all valid flags and loads the register defaults; no clearing pass.
// Depends on adsr_pkg, adsr_divider, adsr_div_cell and the assertion header.
`default_nettype none
`include "adsr_envelope_generator_top_assert.svh"
module adsr_envelope_generator_top #(
	parameter int TIME_BITS       = adsr_pkg::TIME_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // now_ticks[31:0], on_ticks[63:32], off_ticks[95:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // level[15:0]
	output logic [2:0]  m_tuser,   // phase[1:0], silent[2]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int TB  = TIME_BITS;
	localparam int LW  = LEVEL_FRAC_BITS + 1;
	localparam int SW  = (LW > 16) ? LW : 16;
	localparam int XW  = (TB > 25) ? TB : 25;
	localparam int CW  = adsr_pkg::CFG_W;
	localparam int NW  = CW + LW;
	localparam int FW  = adsr_pkg::FIELD_W;
	localparam logic [SW-1:0] ONE_S = {{(SW-1){1'b0}}, 1'b1} << LEVEL_FRAC_BITS;
	// sideband of the first divider: held, phase, base, sub, rz, rd
	localparam int SB1 = 1 + 2 + LW + 1 + 1 + CW;

	// configuration registers
	logic [CW-1:0] att_q, dec_q, rel_q;
	logic [15:0]   start_q, sus_q, floor_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q   <= adsr_pkg::ATTACK_RST;
			dec_q   <= adsr_pkg::DECAY_RST;
			rel_q   <= adsr_pkg::RELEASE_RST;
			start_q <= adsr_pkg::START_RST;
			sus_q   <= adsr_pkg::SUSTAIN_RST;
			floor_q <= adsr_pkg::FLOOR_RST;
		end else if (cfg_valid) begin
			unique case (adsr_pkg::cfg_reg_t'(cfg_index))
				adsr_pkg::REG_ATTACK:  att_q   <= cfg_data;
				adsr_pkg::REG_DECAY:   dec_q   <= cfg_data;
				adsr_pkg::REG_RELEASE: rel_q   <= cfg_data;
				adsr_pkg::REG_START:   start_q <= cfg_data[15:0];
				adsr_pkg::REG_SUSTAIN: sus_q   <= cfg_data[15:0];
				adsr_pkg::REG_FLOOR:   floor_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// saturated levels
	logic [SW-1:0] st_x, su_x;
	logic [LW-1:0] st_l, su_l;
	always_comb begin
		st_x = SW'(start_q);
		su_x = SW'(sus_q);
		if (st_x > ONE_S) st_x = ONE_S;
		if (su_x > ONE_S) su_x = ONE_S;
		st_l = st_x[LW-1:0];
		su_l = su_x[LW-1:0];
	end

	// stage ready chain
	logic v1_q, v2_q, v3_q, v4_q, v5_q, mv_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic d1_in_rdy, d1_out_v, d2_in_rdy, d2_out_v, d2_out_rdy;

	assign rdy1 = !v1_q || rdy2;
	assign rdy2 = !v2_q || rdy3;
	assign rdy3 = !v3_q || d1_in_rdy;
	assign rdy4 = !v4_q || rdy5;
	assign rdy5 = !v5_q || d2_in_rdy;
	assign d2_out_rdy = !mv_q || m_tready;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			mv_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= s_tvalid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= d1_out_v;
			if (rdy5) v5_q <= v4_q;
			if (d2_out_rdy) mv_q <= d2_out_v;
		end
	end

	// s1: elapsed times
	logic [TB-1:0] now_t, on_t, off_t, life_c, e_c;
	logic          held_c;
	logic [TB-1:0] life_s1, e_s1;
	logic          held_s1;
	always_comb begin
		now_t  = TB'(s_tdata[FW-1:0]);
		on_t   = TB'(s_tdata[2*FW-1:FW]);
		off_t  = TB'(s_tdata[3*FW-1:2*FW]);
		held_c = on_t > off_t;
		if (held_c) life_c = (now_t > on_t) ? now_t - on_t : '0;
		else        life_c = off_t - on_t;
		e_c = (now_t > off_t) ? now_t - off_t : '0;
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			life_s1 <= life_c;
			e_s1    <= e_c;
			held_s1 <= held_c;
		end
	end

	// s2: phase decision and multiplier operands
	logic [XW-1:0] life_x, a_x, ad_x, t_x, e_x, r_x;
	logic          is_att, is_dec, rz_c, sub_c;
	logic [CW-1:0] ma_c, den1_c, rd_c;
	logic [LW-1:0] mb_c, base_c, dlt_c;
	logic [1:0]    ph_c;
	always_comb begin
		life_x = XW'(life_s1);
		a_x    = XW'(att_q);
		ad_x   = XW'({1'b0, att_q} + {1'b0, dec_q});
		t_x    = life_x - a_x;
		e_x    = XW'(e_s1);
		r_x    = XW'(rel_q);
		is_att = (att_q != '0) && (life_x <= a_x);
		is_dec = !is_att && (dec_q != '0) && (life_x <= ad_x);
		sub_c  = su_l < st_l;
		dlt_c  = sub_c ? st_l - su_l : su_l - st_l;
		if (is_att) begin
			ma_c = life_x[CW-1:0]; mb_c = st_l; den1_c = att_q;
			base_c = '0; ph_c = adsr_pkg::PH_ATTACK;
		end else if (is_dec) begin
			ma_c = t_x[CW-1:0]; mb_c = dlt_c; den1_c = dec_q;
			base_c = st_l; ph_c = adsr_pkg::PH_DECAY;
		end else begin
			ma_c = '0; mb_c = '0; den1_c = CW'(1);
			base_c = su_l; ph_c = adsr_pkg::PH_SUSTAIN;
		end
		rz_c = (rel_q == '0) || (e_x >= r_x);
		rd_c = rel_q - e_x[CW-1:0];
	end

	logic [CW-1:0] ma_s2, den1_s2, rd_s2;
	logic [LW-1:0] mb_s2, base_s2;
	logic [1:0]    ph_s2;
	logic          held_s2, sub_s2, rz_s2;
	always_ff @(posedge clk) begin
		if (rdy2 && v1_q) begin
			ma_s2   <= ma_c;
			mb_s2   <= mb_c;
			den1_s2 <= den1_c;
			base_s2 <= base_c;
			ph_s2   <= ph_c;
			held_s2 <= held_s1;
			sub_s2  <= is_dec && sub_c;
			rz_s2   <= rz_c;
			rd_s2   <= rd_c;
		end
	end

	// s3: held-curve product
	logic [NW-1:0]  num1_s3;
	logic [CW-1:0]  den1_s3;
	logic [SB1-1:0] sb1_s3;
	always_ff @(posedge clk) begin
		if (rdy3 && v2_q) begin
			num1_s3 <= NW'(ma_s2) * NW'(mb_s2);
			den1_s3 <= den1_s2;
			sb1_s3  <= {rd_s2, rz_s2, sub_s2, base_s2, ph_s2, held_s2};
		end
	end

	logic [LW-1:0]  quo1;
	logic [SB1-1:0] sb1_o;
	adsr_divider #(.DW(CW), .QB(LW), .SBW(SB1)) u_div_held (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v3_q),
		.in_ready (d1_in_rdy),
		.in_num   (num1_s3),
		.in_den   (den1_s3),
		.in_sb    (sb1_s3),
		.out_valid(d1_out_v),
		.out_ready(rdy4),
		.out_quo  (quo1),
		.out_sb   (sb1_o)
	);

	// s4: held level, release operands
	logic          h_held, h_sub, h_rz;
	logic [1:0]    h_ph;
	logic [LW-1:0] h_base, lvl_h;
	logic [CW-1:0] h_rd;
	always_comb begin
		h_held = sb1_o[0];
		h_ph   = sb1_o[2:1];
		h_base = sb1_o[LW+2:3];
		h_sub  = sb1_o[LW+3];
		h_rz   = sb1_o[LW+4];
		h_rd   = sb1_o[SB1-1:LW+5];
		lvl_h  = h_sub ? h_base - quo1 : h_base + quo1;
	end

	logic [CW-1:0] x_s4, den2_s4;
	logic [LW-1:0] y_s4;
	logic [1:0]    ph_s4;
	always_ff @(posedge clk) begin
		if (rdy4 && d1_out_v) begin
			y_s4    <= lvl_h;
			x_s4    <= h_held ? CW'(1) : (h_rz ? '0 : h_rd);
			den2_s4 <= (h_held || h_rz) ? CW'(1) : rel_q;
			ph_s4   <= h_held ? h_ph : adsr_pkg::PH_RELEASE;
		end
	end

	// s5: release product
	logic [NW-1:0] num2_s5;
	logic [CW-1:0] den2_s5;
	logic [1:0]    ph_s5;
	always_ff @(posedge clk) begin
		if (rdy5 && v4_q) begin
			num2_s5 <= NW'(x_s4) * NW'(y_s4);
			den2_s5 <= den2_s4;
			ph_s5   <= ph_s4;
		end
	end

	logic [LW-1:0] quo2;
	logic [1:0]    ph_o;
	adsr_divider #(.DW(CW), .QB(LW), .SBW(2)) u_div_rel (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v5_q),
		.in_ready (d2_in_rdy),
		.in_num   (num2_s5),
		.in_den   (den2_s5),
		.in_sb    (ph_s5),
		.out_valid(d2_out_v),
		.out_ready(d2_out_rdy),
		.out_quo  (quo2),
		.out_sb   (ph_o)
	);

	// floor test and output register
	logic [SW-1:0] q2_x;
	logic          sil_c;
	always_comb begin
		q2_x  = SW'(quo2);
		sil_c = q2_x <= SW'(floor_q);
	end

	logic [15:0] level_q;
	logic [2:0]  user_q;
	always_ff @(posedge clk) begin
		if (d2_out_rdy && d2_out_v) begin
			level_q <= sil_c ? 16'd0 : q2_x[15:0];
			user_q  <= {sil_c, ph_o};
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = level_q;
	assign m_tuser  = user_q;

	// checks
	`ADSR_ASSERT_IMP(a_den1_nz, v3_q, den1_s3 != '0, "held divider sees zero divisor")
	`ADSR_ASSERT_IMP(a_den2_nz, v4_q, den2_s4 != '0, "release divider sees zero divisor")
	`ADSR_ASSERT_IMP(a_quo1_rng, d1_out_v, SW'(quo1) <= ONE_S, "held quotient above one")
	`ADSR_ASSERT_IMP(a_sil_zero, m_tvalid && m_tuser[2], m_tdata == 16'd0,
		"silent word with nonzero level")
	`ADSR_ASSERT_NXT(a_cfg_att, cfg_valid && cfg_index == adsr_pkg::REG_ATTACK,
		att_q == $past(cfg_data), "attack register not updated")

endmodule
`default_nettype wire

// File: tb/sv/adsr_envelope_generator_top_tb.sv
// Self-checking testbench for the linear ADSR envelope generator.
// Depends on adsr_pkg and adsr_envelope_generator_top; drives queries and register writes.
`default_nettype none
module adsr_envelope_generator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] off_t;
		logic [31:0] on_t;
		logic [31:0] now_t;
	} query_t;

	typedef struct packed {
		logic             silent;
		adsr_pkg::phase_t phase;
		logic [15:0]      level;
	} env_t;

	localparam longint LVL_ONE = 64'd32768;
	localparam int     LATENCY = 38;
	localparam longint CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	adsr_envelope_generator_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// local copy of the envelope registers
	longint atk_t, dec_t, rel_t, start_lv, sus_lv, floor_lv;

	query_t pending_q[$];
	env_t   expected_env_q[$];
	int     error_count;
	int     words_out;
	longint cycle_count;
	bit     no_idle;
	bit     hold_sender;
	bit     in_taken;

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0d: %s", cycle_count, what);
		error_count++;
	endtask

	// append a query to the pending list
	task automatic queue_query(input query_t q);
		pending_q = {pending_q, q};
	endtask

	// held curve level after life ticks
	function automatic longint held_curve(input longint life, output adsr_pkg::phase_t ph);
		longint st, su, t;
		st = (start_lv > LVL_ONE) ? LVL_ONE : start_lv;
		su = (sus_lv > LVL_ONE) ? LVL_ONE : sus_lv;
		if (atk_t > 0 && life <= atk_t) begin
			ph = adsr_pkg::PH_ATTACK;
			return (life * st) / atk_t;
		end
		if (dec_t > 0 && life <= atk_t + dec_t) begin
			t = life - atk_t;
			ph = adsr_pkg::PH_DECAY;
			if (su >= st) return st + (t * (su - st)) / dec_t;
			return st - (t * (st - su)) / dec_t;
		end
		ph = adsr_pkg::PH_SUSTAIN;
		return su;
	endfunction

	function automatic env_t envelope_of(input query_t q);
		env_t             r;
		longint           now_v, on_v, off_v, lvl, rl, e;
		adsr_pkg::phase_t ph, dummy;
		now_v = q.now_t; on_v = q.on_t; off_v = q.off_t;
		if (on_v > off_v) begin
			lvl = held_curve((now_v > on_v) ? now_v - on_v : 0, ph);
		end else begin
			rl = held_curve(off_v - on_v, dummy);
			e = (now_v > off_v) ? now_v - off_v : 0;
			ph = adsr_pkg::PH_RELEASE;
			if (rel_t == 0 || e >= rel_t) lvl = 0;
			else lvl = (rl * (rel_t - e)) / rel_t;
		end
		r.silent = 1'b0;
		if (lvl <= floor_lv) begin
			lvl = 0;
			r.silent = 1'b1;
		end
		r.level = lvl[15:0];
		r.phase = ph;
		return r;
	endfunction

	// register write over the config channel, block idle
	task automatic write_reg(input adsr_pkg::cfg_reg_t idx, input longint val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[23:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			adsr_pkg::REG_ATTACK:  atk_t = val & 24'hFFFFFF;
			adsr_pkg::REG_DECAY:   dec_t = val & 24'hFFFFFF;
			adsr_pkg::REG_RELEASE: rel_t = val & 24'hFFFFFF;
			adsr_pkg::REG_START:   start_lv = val & 16'hFFFF;
			adsr_pkg::REG_SUSTAIN: sus_lv = val & 16'hFFFF;
			default:               floor_lv = val & 16'hFFFF;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || expected_env_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_all(input longint a, d, r, st, su, fl);
		write_reg(adsr_pkg::REG_ATTACK, a);
		write_reg(adsr_pkg::REG_DECAY, d);
		write_reg(adsr_pkg::REG_RELEASE, r);
		write_reg(adsr_pkg::REG_START, st);
		write_reg(adsr_pkg::REG_SUSTAIN, su);
		write_reg(adsr_pkg::REG_FLOOR, fl);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFFFFFF;
			2: return $urandom_range(0, 100);
			default: return $urandom;
		endcase
	endfunction

	// well-formed note: times near each other so every phase is reached
	task automatic push_note(input int span);
		query_t q;
		logic [31:0] base;
		base = $urandom;
		if (base > 32'hF0000000) base = base - 32'h20000000;
		q.on_t = base;
		q.off_t = base + $urandom_range(0, span);
		if ($urandom_range(0, 3) == 0) q.off_t = base - $urandom_range(0, span);
		if ($urandom_range(0, 9) == 0) q.off_t = base;
		q.now_t = base + $urandom_range(0, 2 * span) - $urandom_range(0, span / 8 + 1);
		queue_query(q);
	endtask

	// driver: inputs change on the falling edge; a waiting word is held
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (pending_q.size() != 0 && !hold_sender &&
				    (no_idle || $urandom_range(0, 99) >= 35)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_q[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= no_idle || $urandom_range(0, 99) >= 35;
		end
	end

	// monitor: predict at acceptance, check results at the rising edge
	always @(posedge clk) begin
		env_t got, exp_r;
		cycle_count++;
		in_taken = arst_n && s_tvalid && s_tready;
		if (in_taken) begin
			expected_env_q = {expected_env_q, envelope_of(s_tdata)};
			void'(pending_q.pop_front());
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser[2], m_tuser[1:0], m_tdata};
			words_out++;
			if (expected_env_q.size() == 0) begin
				report_mismatch("result word with none expected");
			end else begin
				exp_r = expected_env_q.pop_front();
				if (got.level !== exp_r.level)
					report_mismatch($sformatf("level %0d expected %0d",
						got.level, exp_r.level));
				if (got.phase !== exp_r.phase)
					report_mismatch($sformatf("phase %0d expected %0d",
						got.phase, exp_r.phase));
				if (got.silent !== exp_r.silent)
					report_mismatch($sformatf("silent %0b expected %0b",
						got.silent, exp_r.silent));
			end
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		query_t q;
		int     n;
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		cfg_valid = 1'b0; cfg_index = adsr_pkg::REG_ATTACK; cfg_data = '0;
		error_count = 0; words_out = 0; cycle_count = 0;
		no_idle = 1'b0; hold_sender = 1'b0; in_taken = 1'b0;
		atk_t = adsr_pkg::ATTACK_RST; dec_t = adsr_pkg::DECAY_RST;
		rel_t = adsr_pkg::RELEASE_RST; start_lv = adsr_pkg::START_RST;
		sus_lv = adsr_pkg::SUSTAIN_RST; floor_lv = adsr_pkg::FLOOR_RST;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: extremes, each phase, equal on/off, now before on/off
		q = '{off_t: 32'd0, on_t: 32'd100, now_t: 32'd100};        queue_query(q);
		q = '{off_t: 32'd0, on_t: 32'd100, now_t: 32'd50};         queue_query(q);
		q = '{off_t: 32'd0, on_t: 32'd100, now_t: 32'd2305};       queue_query(q);
		q = '{off_t: 32'd0, on_t: 32'd100, now_t: 32'd4510};       queue_query(q);
		q = '{off_t: 32'd0, on_t: 32'd100, now_t: 32'd6000};       queue_query(q);
		q = '{off_t: 32'd0, on_t: 32'd100, now_t: 32'd9000};       queue_query(q);
		q = '{off_t: 32'd6000, on_t: 32'd100, now_t: 32'd8000};    queue_query(q);
		q = '{off_t: 32'd6000, on_t: 32'd100, now_t: 32'd5000};    queue_query(q);
		q = '{off_t: 32'd6000, on_t: 32'd100, now_t: 32'd20000};   queue_query(q);
		q = '{off_t: 32'd500, on_t: 32'd500, now_t: 32'd600};      queue_query(q);
		q = '{off_t: 32'hFFFFFFFF, on_t: 32'hFFFFFFFF, now_t: 32'hFFFFFFFF};
		queue_query(q);
		q = '{off_t: 32'd0, on_t: 32'hFFFFFFFF, now_t: 32'd0};     queue_query(q);
		q = '{off_t: 32'hFFFFFFFF, on_t: 32'd0, now_t: 32'hFFFFFFFF};
		queue_query(q);
		q = '{off_t: 32'd0, on_t: 32'd0, now_t: 32'd0};            queue_query(q);
		drain();

		// zero-length phases, over-range levels, decaying down, top floor
		set_all(0, 0, 0, 16'hFFFF, 16'd40000, 0);
		q = '{off_t: 32'd0, on_t: 32'd10, now_t: 32'd10};          queue_query(q);
		q = '{off_t: 32'd0, on_t: 32'd10, now_t: 32'd99};          queue_query(q);
		q = '{off_t: 32'd50, on_t: 32'd10, now_t: 32'd50};         queue_query(q);
		drain();
		set_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32768, 0, 32768);
		q = '{off_t: 32'd0, on_t: 32'd1, now_t: 32'h00FFFFF0};     queue_query(q);
		drain();
		set_all(100, 200, 300, 30000, 10000, 0);
		q = '{off_t: 32'd0, on_t: 32'd1, now_t: 32'd201};          queue_query(q);
		q = '{off_t: 32'd151, on_t: 32'd1, now_t: 32'd300};        queue_query(q);
		drain();

		// random phases with several register settings
		n = 0;
		while (n < 1950) begin
			case ((n / 200) % 5)
				0: set_all($urandom_range(0, 300), $urandom_range(0, 300),
					$urandom_range(0, 600), $urandom_range(0, 65535),
					$urandom_range(0, 32768), $urandom_range(0, 2000));
				1: set_all($urandom_range(1, 5000), $urandom_range(0, 5000),
					$urandom_range(1, 9000), $urandom_range(0, 32768),
					$urandom_range(0, 65535), $urandom_range(0, 400));
				2: set_all($urandom & 24'hFFFFFF, $urandom & 24'hFFFFFF,
					$urandom & 24'hFFFFFF, $urandom & 16'hFFFF,
					$urandom & 16'hFFFF, $urandom & 16'hFFFF);
				3: set_all(adsr_pkg::ATTACK_RST, adsr_pkg::DECAY_RST,
					adsr_pkg::RELEASE_RST, adsr_pkg::START_RST,
					adsr_pkg::SUSTAIN_RST, adsr_pkg::FLOOR_RST);
				default: set_all($urandom_range(0, 3), $urandom_range(0, 3),
					$urandom_range(0, 3), 32768, $urandom_range(0, 32768), 0);
			endcase
			no_idle = ((n / 200) % 5) == 3;
			repeat (200) begin
				if ($urandom_range(0, 4) == 0) begin
					q = '{off_t: rand_word(), on_t: rand_word(), now_t: rand_word()};
					queue_query(q);
				end else begin
					push_note(((n / 200) % 5) == 2 ? 32'h01FFFFFF :
						((n / 200) % 5) == 4 ? 16 : 20000);
				end
				n++;
				// sender waits for the pipeline to empty once
				if (n == 700) begin
					while (pending_q.size() != 0) @(posedge clk);
					hold_sender = 1'b1;
					while (expected_env_q.size() != 0) @(posedge clk);
					hold_sender = 1'b0;
				end
			end
			drain();
		end

		drain();
		$display("Ran %0d query words over directed cases and ten register settings,", words_out);
		$display("covering every envelope phase, zero-length phases and floor edges.");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
`default_nettype wire
